>>> design/amgt_pkg.sv
// Package for the adjacency matrix graph traversal block.
// Holds the shared constants, operation codes and controller/datapath types.
// No dependencies.
`timescale 1ns / 1ps

package amgt_pkg;

   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam int FIELD_VERTICES       = 16;
   localparam int VERTEX_W             = 4;
   localparam int KIND_W               = 2;
   localparam int COUNT_W              = 5;
   localparam int ADDR_W               = 3;
   localparam int DATA_W               = 32;

   localparam logic [COUNT_W-1:0] COUNT_RESET      = 5'd16;
   localparam logic [0:0]         REG_VERTEX_COUNT = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_DIRECTED   = 2'd0,
      KIND_UNDIRECTED = 2'd1,
      KIND_SWEEP      = 2'd2,
      KIND_DEPTH      = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP_HEAD,
      ST_SWEEP_SCAN,
      ST_DEPTH_SCAN,
      ST_FLUSH
   } state_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_EDGE,
      DP_SWEEP_INIT,
      DP_SWEEP_HEAD,
      DP_SWEEP_SCAN,
      DP_DEPTH_INIT,
      DP_DEPTH_STEP,
      DP_FLUSH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic start_ok;
      logic head_hit;
      logic scan_hit;
      logic row_last;
      logic col_last;
      logic depth_push;
      logic depth_pop;
      logic depth_one;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

endpackage

>>> design/amgt_ctrl.sv
// Controller state machine of the graph traversal block.
// Sequences edge inserts and both traversal orders; depends on amgt_pkg.
`timescale 1ns / 1ps

module amgt_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [amgt_pkg::KIND_W-1:0]     req_kind,
   output logic                            req_ready,
   input  amgt_pkg::dp_status_type         status,
   output amgt_pkg::ctrl_cmd_type          cmd
);

   amgt_pkg::state_type state_ff, state_in;
   logic need_emit;
   logic blocked;

   // An emission moves the pending result into the output register, so it
   // has to wait while that register is still held by the receiver.
   always_comb begin
      case (state_ff)
         amgt_pkg::ST_SWEEP_HEAD: need_emit = status.head_hit;
         amgt_pkg::ST_SWEEP_SCAN: need_emit = status.scan_hit;
         amgt_pkg::ST_DEPTH_SCAN: need_emit = status.depth_push;
         amgt_pkg::ST_FLUSH:      need_emit = 1'b1;
         default:                 need_emit = 1'b0;
      endcase
      blocked = need_emit && status.pend_valid && !status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         amgt_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (amgt_pkg::kind_type'(req_kind))
                  amgt_pkg::KIND_SWEEP: begin
                     if (!status.cnt_zero) state_in = amgt_pkg::ST_SWEEP_HEAD;
                  end
                  amgt_pkg::KIND_DEPTH: begin
                     if (status.start_ok) state_in = amgt_pkg::ST_DEPTH_SCAN;
                  end
                  default: state_in = amgt_pkg::ST_IDLE;
               endcase
            end
         end
         amgt_pkg::ST_SWEEP_HEAD: begin
            if (!blocked) state_in = amgt_pkg::ST_SWEEP_SCAN;
         end
         amgt_pkg::ST_SWEEP_SCAN: begin
            if (!blocked && status.col_last) begin
               if (status.row_last) state_in = amgt_pkg::ST_FLUSH;
               else                 state_in = amgt_pkg::ST_SWEEP_HEAD;
            end
         end
         amgt_pkg::ST_DEPTH_SCAN: begin
            if (!blocked && status.depth_pop && status.depth_one)
               state_in = amgt_pkg::ST_FLUSH;
         end
         amgt_pkg::ST_FLUSH: begin
            if (!blocked) state_in = amgt_pkg::ST_IDLE;
         end
         default: state_in = amgt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == amgt_pkg::ST_IDLE);
      cmd.op    = amgt_pkg::DP_NONE;
      case (state_ff)
         amgt_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (amgt_pkg::kind_type'(req_kind))
                  amgt_pkg::KIND_DIRECTED,
                  amgt_pkg::KIND_UNDIRECTED: cmd.op = amgt_pkg::DP_EDGE;
                  amgt_pkg::KIND_SWEEP: begin
                     if (!status.cnt_zero) cmd.op = amgt_pkg::DP_SWEEP_INIT;
                  end
                  amgt_pkg::KIND_DEPTH: begin
                     if (status.start_ok) cmd.op = amgt_pkg::DP_DEPTH_INIT;
                  end
                  default: cmd.op = amgt_pkg::DP_NONE;
               endcase
            end
         end
         amgt_pkg::ST_SWEEP_HEAD: if (!blocked) cmd.op = amgt_pkg::DP_SWEEP_HEAD;
         amgt_pkg::ST_SWEEP_SCAN: if (!blocked) cmd.op = amgt_pkg::DP_SWEEP_SCAN;
         amgt_pkg::ST_DEPTH_SCAN: if (!blocked) cmd.op = amgt_pkg::DP_DEPTH_STEP;
         amgt_pkg::ST_FLUSH: begin
            if (!blocked && status.pend_valid) cmd.op = amgt_pkg::DP_FLUSH;
         end
         default: cmd.op = amgt_pkg::DP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amgt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/amgt_datapath.sv
// Datapath of the graph traversal block: adjacency matrix, visited mask,
// scan counters, walk stack and the pending/output result registers.
// Depends on amgt_pkg; driven by amgt_ctrl through a command struct.
`timescale 1ns / 1ps

module amgt_datapath #(
   parameter int MAX_VERTICES = amgt_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  amgt_pkg::ctrl_cmd_type            cmd,
   output amgt_pkg::dp_status_type           status,
   input  logic [amgt_pkg::COUNT_W-1:0]      vertex_count,
   input  logic [amgt_pkg::KIND_W-1:0]       req_kind,
   input  logic [amgt_pkg::VERTEX_W-1:0]     req_from_vertex,
   input  logic [amgt_pkg::VERTEX_W-1:0]     req_to_vertex,
   input  logic [amgt_pkg::VERTEX_W-1:0]     req_start_vertex,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [amgt_pkg::VERTEX_W-1:0]     rsp_vertex,
   output logic                              rsp_last
);

   localparam int NV = (MAX_VERTICES < amgt_pkg::FIELD_VERTICES) ?
                       MAX_VERTICES : amgt_pkg::FIELD_VERTICES;
   localparam int VW = $clog2(NV);
   localparam int CW = $clog2(NV + 1);

   logic [NV-1:0]      adj_ff [NV];
   logic [NV-1:0]      visited_ff, visited_in;
   logic [VW-1:0]      row_ff, row_in;
   logic [VW-1:0]      col_ff, col_in;
   logic [VW-1:0]      cur_ff, cur_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      depth_ff, depth_in;
   logic [CW+VW-1:0]   stack_ff [NV];
   logic               pend_valid_ff, pend_valid_in;
   logic [VW-1:0]      pend_vertex_ff, pend_vertex_in;
   logic               out_valid_ff, out_valid_in;
   logic [VW-1:0]      out_vertex_ff, out_vertex_in;
   logic               out_last_ff, out_last_in;

   logic [CW-1:0]      cnt;
   logic [VW-1:0]      from_idx, to_idx, start_idx, idx_v;
   logic               edge_ok, depth_end, depth_hit, depth_full;
   logic               emit_en;
   logic [VW-1:0]      emit_v;
   logic               stack_we;
   logic [VW-1:0]      stack_wa;
   logic [CW+VW-1:0]   stack_wd;

   // The count in use is capped at the size of the matrix.
   always_comb begin
      if (vertex_count > amgt_pkg::COUNT_W'(NV)) cnt = CW'(NV);
      else                                       cnt = CW'(vertex_count);
   end

   assign from_idx  = req_from_vertex[VW-1:0];
   assign to_idx    = req_to_vertex[VW-1:0];
   assign start_idx = req_start_vertex[VW-1:0];
   assign idx_v     = idx_ff[VW-1:0];
   assign edge_ok   = (req_from_vertex < cnt) && (req_to_vertex < cnt);

   assign depth_end  = (idx_ff >= cnt);
   assign depth_hit  = !depth_end && adj_ff[idx_v][cur_ff] && !visited_ff[idx_v];
   assign depth_full = (depth_ff >= CW'(NV));

   always_comb begin
      status.cnt_zero   = (cnt == '0);
      status.start_ok   = (req_start_vertex < cnt);
      status.head_hit   = !visited_ff[row_ff];
      status.scan_hit   = adj_ff[row_ff][col_ff] && !visited_ff[col_ff];
      status.row_last   = (CW'(row_ff) == CW'(cnt - 1'b1));
      status.col_last   = (CW'(col_ff) == CW'(cnt - 1'b1));
      status.depth_push = depth_hit && !depth_full;
      status.depth_pop  = depth_end || (depth_hit && depth_full);
      status.depth_one  = (depth_ff == CW'(1));
      status.pend_valid = pend_valid_ff;
      status.out_free   = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      visited_in     = visited_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      cur_in         = cur_ff;
      idx_in         = idx_ff;
      depth_in       = depth_ff;
      pend_valid_in  = pend_valid_ff;
      pend_vertex_in = pend_vertex_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_vertex_in  = out_vertex_ff;
      out_last_in    = out_last_ff;
      emit_en        = 1'b0;
      emit_v         = '0;
      stack_we       = 1'b0;
      stack_wa       = '0;
      stack_wd       = '0;

      case (cmd.op)
         amgt_pkg::DP_SWEEP_INIT: begin
            visited_in = '0;
            row_in     = '0;
            col_in     = '0;
         end
         amgt_pkg::DP_SWEEP_HEAD: begin
            if (status.head_hit) begin
               emit_en = 1'b1;
               emit_v  = row_ff;
            end
            col_in = '0;
         end
         amgt_pkg::DP_SWEEP_SCAN: begin
            if (status.scan_hit) begin
               emit_en = 1'b1;
               emit_v  = col_ff;
            end
            if (status.col_last) begin
               col_in = '0;
               row_in = VW'(row_ff + 1'b1);
            end else begin
               col_in = VW'(col_ff + 1'b1);
            end
         end
         amgt_pkg::DP_DEPTH_INIT: begin
            visited_in = '0;
            emit_en    = 1'b1;
            emit_v     = start_idx;
            cur_in     = start_idx;
            idx_in     = '0;
            depth_in   = CW'(1);
         end
         amgt_pkg::DP_DEPTH_STEP: begin
            if (status.depth_pop) begin
               // Return to the frame below and resume its scan.
               depth_in = CW'(depth_ff - 1'b1);
               if (!status.depth_one) begin
                  {idx_in, cur_in} = stack_ff[VW'(depth_ff - 2'd2)];
               end
            end else if (depth_hit) begin
               stack_we = 1'b1;
               stack_wa = VW'(depth_ff - 1'b1);
               stack_wd = {CW'(idx_ff + 1'b1), cur_ff};
               cur_in   = idx_v;
               idx_in   = '0;
               depth_in = CW'(depth_ff + 1'b1);
               emit_en  = 1'b1;
               emit_v   = idx_v;
            end else begin
               idx_in = CW'(idx_ff + 1'b1);
            end
         end
         amgt_pkg::DP_FLUSH: begin
            out_valid_in  = 1'b1;
            out_vertex_in = pend_vertex_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end
         default: begin
         end
      endcase

      // A new vertex pushes the one held back into the output register; the
      // held one is known not to be the last of the traversal.
      if (emit_en) begin
         visited_in = visited_in | (NV'(1) << emit_v);
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_vertex_in = pend_vertex_ff;
            out_last_in   = 1'b0;
         end
         pend_valid_in  = 1'b1;
         pend_vertex_in = emit_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adj_ff <= '{default: '0};
      end else if (cmd.op == amgt_pkg::DP_EDGE && edge_ok) begin
         adj_ff[from_idx][to_idx] <= 1'b1;
         if (req_kind == amgt_pkg::KIND_UNDIRECTED) adj_ff[to_idx][from_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_ff[stack_wa] <= stack_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff    <= '0;
         depth_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         visited_ff    <= visited_in;
         depth_ff      <= depth_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      col_ff         <= col_in;
      cur_ff         <= cur_in;
      idx_ff         <= idx_in;
      pend_vertex_ff <= pend_vertex_in;
      out_vertex_ff  <= out_vertex_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_vertex = amgt_pkg::VERTEX_W'(out_vertex_ff);
   assign rsp_last   = out_last_ff;

endmodule

>>> design/adjacency_matrix_graph_traversal.sv
// Adjacency matrix graph traversal block: edge inserts, row sweep and
// depth-first walk over a bit matrix of up to 16 vertices.
//
// Usage. Each req_ transaction carries a kind: add a directed edge, add an
// undirected edge, run a row sweep or run a depth-first walk from
// req_start_vertex. Edge inserts return nothing and leave the block ready; an edge
// naming a vertex at or beyond the count in use is dropped. A traversal
// returns one rsp_ transaction per visited vertex, rsp_last marking the final
// one. Results are held back one vertex so that the last can be flagged,
// then pass through an output register.
// Sequencing. With n vertices in use the controller examines one matrix
// entry a cycle, unless the receiver holds rsp_ready low while a result
// waits: a row sweep checks each row head and then scans its columns; a
// depth-first walk scans column entries, pushes each new vertex and pops
// once per visited vertex. The next transaction is taken once the final
// result sits in the output register. The register vertex_count is written
// over the APB-style port; the user must write it only while the block is
// idle, which the block itself does not enforce. Reset clears the matrix,
// the visited mask and the result registers, and sets vertex_count to 16.
// Depends on amgt_pkg, amgt_ctrl and amgt_datapath.
`timescale 1ns / 1ps

module adjacency_matrix_graph_traversal #(
   parameter int MAX_VERTICES = amgt_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [amgt_pkg::KIND_W-1:0]       req_kind,
   input  logic [amgt_pkg::VERTEX_W-1:0]     req_from_vertex,
   input  logic [amgt_pkg::VERTEX_W-1:0]     req_to_vertex,
   input  logic [amgt_pkg::VERTEX_W-1:0]     req_start_vertex,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [amgt_pkg::VERTEX_W-1:0]     rsp_vertex,
   output logic                              rsp_last,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [amgt_pkg::ADDR_W-1:0]       paddr,
   input  logic [amgt_pkg::DATA_W-1:0]       pwdata,
   output logic [amgt_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);

   amgt_pkg::ctrl_cmd_type   cmd;
   amgt_pkg::dp_status_type  status;
   logic [amgt_pkg::COUNT_W-1:0] vertex_count_ff;
   logic                         reg_hit;

   assign reg_hit = (paddr[amgt_pkg::ADDR_W-1:2] == amgt_pkg::REG_VERTEX_COUNT);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= amgt_pkg::COUNT_RESET;
      end else if (psel && penable && pwrite && reg_hit) begin
         vertex_count_ff <= pwdata[amgt_pkg::COUNT_W-1:0];
      end
   end

   always_comb begin
      if (reg_hit) prdata = amgt_pkg::DATA_W'(vertex_count_ff);
      else         prdata = '0;
   end

   amgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   amgt_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .vertex_count     (vertex_count_ff),
      .req_kind         (req_kind),
      .req_from_vertex  (req_from_vertex),
      .req_to_vertex    (req_to_vertex),
      .req_start_vertex (req_start_vertex),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_vertex       (rsp_vertex),
      .rsp_last         (rsp_last)
   );

   // An edge insert finishes in its own cycle.
   a_edge_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_kind == amgt_pkg::KIND_DIRECTED || req_kind == amgt_pkg::KIND_UNDIRECTED))
      |=> req_ready)
      else $error("edge insert did not return to idle");

   // A row sweep accepted with a non-zero vertex count makes the block busy.
   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == amgt_pkg::KIND_SWEEP &&
       vertex_count_ff != '0)
      |=> !req_ready)
      else $error("row sweep accepted but block still idle");

   // A completed register write lands in vertex_count.
   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && reg_hit)
      |=> vertex_count_ff == $past(pwdata[amgt_pkg::COUNT_W-1:0]))
      else $error("vertex_count write lost");

endmodule

>>> verif/adjacency_matrix_graph_traversal_test.sv
// Self-checking testbench for adjacency_matrix_graph_traversal: edge inserts,
// row sweeps and depth-first walks checked against a behavioural graph model.
// Depends on amgt_pkg and the adjacency_matrix_graph_traversal RTL.
`timescale 1ns / 1ps

module adjacency_matrix_graph_traversal_test;

   localparam int unsigned LIMIT_CYCLES   = 400000;
   localparam int unsigned SETTLE_CYCLES  = 64;
   localparam int unsigned PHASE_ITEMS    = 24;

   typedef struct {
      amgt_pkg::kind_type             kind;
      logic [amgt_pkg::VERTEX_W-1:0]  from_v;
      logic [amgt_pkg::VERTEX_W-1:0]  to_v;
      logic [amgt_pkg::VERTEX_W-1:0]  start_v;
   } graph_op_type;

   typedef struct {
      logic [amgt_pkg::VERTEX_W-1:0]  vertex;
      logic                           last;
   } visit_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [amgt_pkg::KIND_W-1:0]      req_kind = '0;
   logic [amgt_pkg::VERTEX_W-1:0]    req_from_vertex = '0;
   logic [amgt_pkg::VERTEX_W-1:0]    req_to_vertex = '0;
   logic [amgt_pkg::VERTEX_W-1:0]    req_start_vertex = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [amgt_pkg::VERTEX_W-1:0]    rsp_vertex;
   logic                             rsp_last;
   logic                             psel = 1'b0;
   logic                             penable = 1'b0;
   logic                             pwrite = 1'b0;
   logic [amgt_pkg::ADDR_W-1:0]      paddr = '0;
   logic [amgt_pkg::DATA_W-1:0]      pwdata = '0;
   logic [amgt_pkg::DATA_W-1:0]      prdata;
   logic                             pready;

   // Model state: the edge matrix and the count register as last written.
   logic [amgt_pkg::FIELD_VERTICES-1:0] adjacency [amgt_pkg::FIELD_VERTICES];
   logic [amgt_pkg::COUNT_W-1:0]        vertex_count_cfg = amgt_pkg::COUNT_RESET;

   graph_op_type  pending_ops [$];
   graph_op_type  in_flight;
   visit_type     expected_visits [$];
   visit_type     want;
   int unsigned   send_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;
   int unsigned   errors = 0;
   int unsigned   cycle_count = 0;

   adjacency_matrix_graph_traversal i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_from_vertex  (req_from_vertex),
      .req_to_vertex    (req_to_vertex),
      .req_start_vertex (req_start_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex       (rsp_vertex),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned count_in_use();
      int unsigned n;
      n = vertex_count_cfg;
      if (n > amgt_pkg::MAX_VERTICES_DEFAULT) n = amgt_pkg::MAX_VERTICES_DEFAULT;
      if (n > amgt_pkg::FIELD_VERTICES) n = amgt_pkg::FIELD_VERTICES;
      return n;
   endfunction

   // Applies one accepted transaction to the model and queues the vertices
   // that the traversal, if any, will visit.
   function automatic void predict_visits(graph_op_type op);
      int unsigned cnt;
      logic [amgt_pkg::FIELD_VERTICES-1:0] seen;
      int unsigned order [$];
      int unsigned path_v [amgt_pkg::FIELD_VERTICES];
      int unsigned path_next [amgt_pkg::FIELD_VERTICES];
      int unsigned depth;
      int unsigned cur;
      int unsigned i;
      bit found;
      visit_type v;
      cnt = count_in_use();
      seen = '0;
      case (op.kind)
         amgt_pkg::KIND_DIRECTED, amgt_pkg::KIND_UNDIRECTED: begin
            if (op.from_v < cnt && op.to_v < cnt) begin
               adjacency[op.from_v][op.to_v] = 1'b1;
               if (op.kind == amgt_pkg::KIND_UNDIRECTED)
                  adjacency[op.to_v][op.from_v] = 1'b1;
            end
         end
         amgt_pkg::KIND_SWEEP: begin
            for (int unsigned r = 0; r < cnt; r++) begin
               if (!seen[r]) begin
                  seen[r] = 1'b1;
                  order.push_back(r);
               end
               for (int unsigned c = 0; c < cnt; c++) begin
                  if (adjacency[r][c] && !seen[c]) begin
                     seen[c] = 1'b1;
                     order.push_back(c);
                  end
               end
            end
         end
         default: begin
            if (op.start_v < cnt) begin
               seen[op.start_v] = 1'b1;
               order.push_back(op.start_v);
               path_v[0] = op.start_v;
               path_next[0] = 0;
               depth = 1;
               // Each level resumes its column scan just after the vertex it
               // last descended into.
               while (depth > 0) begin
                  cur = path_v[depth-1];
                  i = path_next[depth-1];
                  found = 1'b0;
                  while (!found && i < cnt) begin
                     if (adjacency[i][cur] && !seen[i]) found = 1'b1;
                     else i++;
                  end
                  if (found && depth < amgt_pkg::FIELD_VERTICES) begin
                     path_next[depth-1] = i + 1;
                     seen[i] = 1'b1;
                     order.push_back(i);
                     path_v[depth] = i;
                     path_next[depth] = 0;
                     depth++;
                  end else begin
                     depth--;
                  end
               end
            end
         end
      endcase
      foreach (order[k]) begin
         v.vertex = order[k][amgt_pkg::VERTEX_W-1:0];
         v.last = (k == order.size() - 1);
         expected_visits.push_back(v);
      end
   endfunction

   function automatic logic [amgt_pkg::VERTEX_W-1:0] pick_vertex(int unsigned cnt);
      if (cnt > 0 && $urandom_range(9) != 0)
         return amgt_pkg::VERTEX_W'($urandom_range(cnt - 1));
      return amgt_pkg::VERTEX_W'($urandom_range(amgt_pkg::FIELD_VERTICES - 1));
   endfunction

   function automatic graph_op_type random_op(int unsigned cnt);
      graph_op_type op;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 35) op.kind = amgt_pkg::KIND_DIRECTED;
      else if (roll < 60) op.kind = amgt_pkg::KIND_UNDIRECTED;
      else if (roll < 80) op.kind = amgt_pkg::KIND_SWEEP;
      else op.kind = amgt_pkg::KIND_DEPTH;
      op.from_v = pick_vertex(cnt);
      op.to_v = pick_vertex(cnt);
      op.start_v = pick_vertex(cnt);
      return op;
   endfunction

   function automatic void report_mismatch(string what, int unsigned exp_v,
                                           int unsigned act_v);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
   endfunction

   task automatic queue_op(amgt_pkg::kind_type kind, int unsigned from_v,
                           int unsigned to_v, int unsigned start_v);
      graph_op_type op;
      op.kind = kind;
      op.from_v = amgt_pkg::VERTEX_W'(from_v);
      op.to_v = amgt_pkg::VERTEX_W'(to_v);
      op.start_v = amgt_pkg::VERTEX_W'(start_v);
      pending_ops.push_back(op);
   endtask

   task automatic wait_until_idle();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_valid || expected_visits.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_vertex_count(logic [amgt_pkg::COUNT_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= amgt_pkg::ADDR_W'(4 * amgt_pkg::REG_VERTEX_COUNT);
      pwdata <= amgt_pkg::DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      vertex_count_cfg = value;
      @(negedge clock);
   endtask

   task automatic run_random_phase(logic [amgt_pkg::COUNT_W-1:0] count_value,
                                   int unsigned send_pct, int unsigned stall_pct);
      write_vertex_count(count_value);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
         pending_ops.push_back(random_op(count_in_use()));
         // Halfway through, the sender holds off until the block has drained.
         if (k == PHASE_ITEMS / 2 - 1) wait_until_idle();
      end
      wait_until_idle();
   endtask

   // Driver: presents the next queued transaction once the previous one has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_visits(in_flight);
         if (!req_valid || req_ready) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = pending_ops.pop_front();
               req_kind <= in_flight.kind;
               req_from_vertex <= in_flight.from_v;
               req_to_vertex <= in_flight.to_v;
               req_start_vertex <= in_flight.start_v;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transaction against the oldest expected visit.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_visits.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual vertex %0d last %0d",
                        $time, rsp_vertex, rsp_last);
            end else begin
               want = expected_visits.pop_front();
               if (rsp_vertex !== want.vertex)
                  report_mismatch("vertex", want.vertex, rsp_vertex);
               if (rsp_last !== want.last) report_mismatch("last", want.last, rsp_last);
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  expected_visits.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      foreach (adjacency[r]) adjacency[r] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty graph at the reset count, then a handful of edges at the extremes and traversals over them.
      queue_op(amgt_pkg::KIND_SWEEP, 0, 0, 0);
      queue_op(amgt_pkg::KIND_DEPTH, 0, 0, 15);
      queue_op(amgt_pkg::KIND_DIRECTED, 0, 15, 0);
      queue_op(amgt_pkg::KIND_UNDIRECTED, 15, 3, 0);
      queue_op(amgt_pkg::KIND_DIRECTED, 5, 5, 0);
      queue_op(amgt_pkg::KIND_UNDIRECTED, 7, 8, 0);
      queue_op(amgt_pkg::KIND_DIRECTED, 14, 0, 0);
      queue_op(amgt_pkg::KIND_DIRECTED, 3, 9, 15);
      queue_op(amgt_pkg::KIND_SWEEP, 15, 15, 15);
      queue_op(amgt_pkg::KIND_DEPTH, 15, 15, 0);
      queue_op(amgt_pkg::KIND_DEPTH, 0, 0, 15);
      queue_op(amgt_pkg::KIND_DEPTH, 0, 0, 9);
      wait_until_idle();

      // A zero count drops every edge and silences both traversals.
      write_vertex_count(5'd0);
      queue_op(amgt_pkg::KIND_DIRECTED, 1, 2, 0);
      queue_op(amgt_pkg::KIND_SWEEP, 0, 0, 0);
      queue_op(amgt_pkg::KIND_DEPTH, 0, 0, 0);
      wait_until_idle();

      // Counts beyond sixteen saturate.
      write_vertex_count(5'd31);
      queue_op(amgt_pkg::KIND_SWEEP, 0, 0, 0);
      wait_until_idle();

      // Edges and starts beyond a small count are ignored, while those within it still take effect.
      write_vertex_count(5'd4);
      queue_op(amgt_pkg::KIND_UNDIRECTED, 2, 9, 0);
      queue_op(amgt_pkg::KIND_DIRECTED, 9, 2, 0);
      queue_op(amgt_pkg::KIND_DEPTH, 0, 0, 10);
      queue_op(amgt_pkg::KIND_UNDIRECTED, 1, 2, 0);
      queue_op(amgt_pkg::KIND_DEPTH, 0, 0, 2);
      queue_op(amgt_pkg::KIND_SWEEP, 0, 0, 0);
      wait_until_idle();

      write_vertex_count(5'd1);
      queue_op(amgt_pkg::KIND_SWEEP, 0, 0, 0);
      queue_op(amgt_pkg::KIND_DEPTH, 0, 0, 0);
      queue_op(amgt_pkg::KIND_DEPTH, 0, 0, 1);
      wait_until_idle();

      run_random_phase(5'd16, 0, 0);
      run_random_phase(5'd31, 45, 0);
      run_random_phase(5'd2, 0, 45);
      run_random_phase(5'd12, 37, 37);

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
